// File: rtl/cpt_pkg.sv
`default_nettype none
package cpt_pkg;

   localparam int NODES       = 1024;
   localparam int COMMUNITIES = 64;
   localparam int NODE_W      = 10;
   localparam int IDX_W       = $clog2(COMMUNITIES);
   localparam int SLOT_W      = $clog2(COMMUNITIES + 1);
   localparam int KEY_W       = $clog2(NODES + 1);

   localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(COMMUNITIES);
   localparam logic [KEY_W-1:0]  KEY_EMPTY = KEY_W'(NODES);

   localparam logic [1:0] CMD_MOVE  = 2'd0;
   localparam logic [1:0] CMD_QUERY = 2'd1;
   localparam logic [1:0] CMD_TEST  = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [9:0]  node_a;
      logic [9:0]  node_b;
      logic [5:0]  target_community;
   } req_type;

   typedef struct packed {
      logic signed [6:0] community_of_a;
      logic              same_community;
      logic              status;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0] min_node;
      logic [KEY_W-1:0] count;
   } slot_type;

   function automatic logic [KEY_W-1:0] slot_key(input slot_type s);
      return (s.count != '0) ? s.min_node : KEY_EMPTY;
   endfunction

   // strict canonical order: by key, ties by slot index
   function automatic logic ahead(input logic [KEY_W-1:0] k1, input logic [IDX_W-1:0] i1,
                                  input logic [KEY_W-1:0] k2, input logic [IDX_W-1:0] i2);
      return (k1 < k2) || ((k1 == k2) && (i1 < i2));
   endfunction

endpackage
`default_nettype wire

// File: rtl/cpt_ram.sv
`default_nettype none
module cpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// File: rtl/canonical_partition_table_top.sv
// channel  ports                          direction  accepted when
// request  start, busy, req_data          in         start && !busy at clock edge
// result   rsp_valid, rsp_data            out        each cycle rsp_valid is high
//
// A move makes one pass of 64 slot reads to update the slot ranks, plus a scan of node
// table reads when the moved node was the minimum of its old community; a node that stays
// put skips both, and a query, a test or a rejected item takes neither.
// After reset the node table is cleared, one entry a cycle, with busy high.
// Results cannot be stalled; one registered result per item.
`default_nettype none
module canonical_partition_table_top (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire cpt_pkg::req_type req_data,
   output logic                 rsp_valid,
   output cpt_pkg::rsp_type     rsp_data
);
   import cpt_pkg::*;

   typedef enum logic [11:0] {
      ST_CLEAR = 12'b000000000001,
      ST_IDLE  = 12'b000000000010,
      ST_RDA   = 12'b000000000100,
      ST_RDB   = 12'b000000001000,
      ST_SLO   = 12'b000000010000,
      ST_SLT   = 12'b000000100000,
      ST_SCAN  = 12'b000001000000,
      ST_RANK  = 12'b000010000000,
      ST_FIXT  = 12'b000100000000,
      ST_FIXO  = 12'b001000000000,
      ST_QISS  = 12'b010000000000,
      ST_QOUT  = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0]        cmd_ff, cmd_in;
   logic [NODE_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [IDX_W-1:0]  t_ff, t_in, tp_ff, tp_in;
   logic [SLOT_W-1:0] pa_ff, pa_in, op_ff, op_in;
   logic              same_ff, same_in, rescan_ff, rescan_in;
   logic [KEY_W-1:0]  oko_ff, oko_in, okt_ff, okt_in, nko_ff, nko_in, nkt_ff, nkt_in;
   logic [KEY_W-1:0]  cnto_ff, cnto_in;
   logic [IDX_W:0]    u_ff, u_in;
   logic              pend_ff, pend_in, spend_ff, spend_in;
   logic [IDX_W-1:0]  pv_ff, pv_in, rko_ff, rko_in, rkt_ff, rkt_in;
   logic [NODE_W-1:0] scan_ff, scan_in, sidx_ff, sidx_in, clr_ff, clr_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              node_we;
   logic [NODE_W-1:0] node_wa, node_ra;
   logic [SLOT_W-1:0] node_wd, node_rd;
   logic              slot_we;
   logic [IDX_W-1:0]  slot_wa, slot_ra;
   slot_type          slot_wd, slot_rd;
   logic              rank_we, inv_we;
   logic [IDX_W-1:0]  rank_wa, rank_wd, rank_ra, rank_rd;
   logic [IDX_W-1:0]  inv_wa, inv_wd, inv_ra, inv_rd;

   logic              op_valid, bad;
   logic [KEY_W-1:0]  kv;
   logic              v_is_o, v_is_t;
   logic [IDX_W-1:0]  r_new;

   cpt_ram #(.WIDTH(SLOT_W), .DEPTH(NODES)) u_node_ram (
      .clock(clock), .wr_en(node_we), .wr_addr(node_wa), .wr_data(node_wd),
      .rd_addr(node_ra), .rd_data(node_rd));

   cpt_ram #(.WIDTH($bits(slot_type)), .DEPTH(COMMUNITIES)) u_slot_ram (
      .clock(clock), .wr_en(slot_we), .wr_addr(slot_wa), .wr_data(slot_wd),
      .rd_addr(slot_ra), .rd_data(slot_rd));

   cpt_ram #(.WIDTH(IDX_W), .DEPTH(COMMUNITIES)) u_rank_ram (
      .clock(clock), .wr_en(rank_we), .wr_addr(rank_wa), .wr_data(rank_wd),
      .rd_addr(rank_ra), .rd_data(rank_rd));

   cpt_ram #(.WIDTH(IDX_W), .DEPTH(COMMUNITIES)) u_inv_ram (
      .clock(clock), .wr_en(inv_we), .wr_addr(inv_wa), .wr_data(inv_wd),
      .rd_addr(inv_ra), .rd_data(inv_rd));

   assign op_valid = (op_ff != SLOT_NONE);
   assign kv       = slot_key(slot_rd);
   assign v_is_o   = op_valid && (pv_ff == op_ff[IDX_W-1:0]);
   assign v_is_t   = (pv_ff == tp_ff);
   assign r_new    = rank_rd
                     - IDX_W'(op_valid && ahead(oko_ff, op_ff[IDX_W-1:0], kv, pv_ff))
                     - IDX_W'(ahead(okt_ff, tp_ff, kv, pv_ff))
                     + IDX_W'(op_valid && ahead(nko_ff, op_ff[IDX_W-1:0], kv, pv_ff))
                     + IDX_W'(ahead(nkt_ff, tp_ff, kv, pv_ff));

   assign bad = (req_data.cmd != CMD_MOVE && req_data.cmd != CMD_QUERY
                 && req_data.cmd != CMD_TEST)
                || (32'(req_data.node_a) >= NODES)
                || (req_data.cmd == CMD_MOVE && 32'(req_data.target_community) >= COMMUNITIES)
                || (req_data.cmd == CMD_TEST && 32'(req_data.node_b) >= NODES);

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff; a_in = a_ff; b_in = b_ff; t_in = t_ff; tp_in = tp_ff;
      pa_in = pa_ff; op_in = op_ff; same_in = same_ff; rescan_in = rescan_ff;
      oko_in = oko_ff; okt_in = okt_ff; nko_in = nko_ff; nkt_in = nkt_ff;
      cnto_in = cnto_ff; u_in = u_ff; pend_in = pend_ff; spend_in = spend_ff;
      pv_in = pv_ff; rko_in = rko_ff; rkt_in = rkt_ff;
      scan_in = scan_ff; sidx_in = sidx_ff; clr_in = clr_ff;
      rsp_in = rsp_ff; rsp_valid_in = 1'b0;

      node_we = 1'b0; node_wa = a_ff; node_wd = {1'b0, tp_ff}; node_ra = a_ff;
      slot_we = 1'b0; slot_wa = tp_ff; slot_wd = slot_rd; slot_ra = tp_ff;
      rank_we = 1'b0; rank_wa = pv_ff; rank_wd = r_new; rank_ra = pa_ff[IDX_W-1:0];
      inv_we = 1'b0; inv_wa = r_new; inv_wd = pv_ff; inv_ra = t_ff;

      case (state_ff)
         ST_CLEAR: begin
            node_we = 1'b1;
            node_wa = clr_ff;
            node_wd = SLOT_NONE;
            if (32'(clr_ff) < COMMUNITIES) begin
               slot_we = 1'b1;
               slot_wa = clr_ff[IDX_W-1:0];
               slot_wd = '{min_node: KEY_EMPTY, count: '0};
               rank_we = 1'b1;
               rank_wa = clr_ff[IDX_W-1:0];
               rank_wd = clr_ff[IDX_W-1:0];
               inv_we  = 1'b1;
               inv_wa  = clr_ff[IDX_W-1:0];
               inv_wd  = clr_ff[IDX_W-1:0];
            end
            clr_in = clr_ff + NODE_W'(1);
            if (32'(clr_ff) == NODES - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            node_ra = req_data.node_a;
            inv_ra  = req_data.target_community;
            if (start) begin
               cmd_in = req_data.cmd;
               a_in   = req_data.node_a;
               b_in   = req_data.node_b;
               t_in   = req_data.target_community;
               if (bad) begin
                  rsp_in       = '{community_of_a: -7'sd1, same_community: 1'b0, status: 1'b1};
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = ST_RDA;
               end
            end
         end
         ST_RDA: begin
            pa_in = node_rd;
            case (cmd_ff)
               CMD_TEST: begin
                  node_ra  = b_ff;
                  state_in = ST_RDB;
               end
               CMD_MOVE: begin
                  tp_in = inv_rd;
                  pa_in = {1'b0, inv_rd};
                  if (node_rd == {1'b0, inv_rd}) begin
                     state_in = ST_QISS;
                  end else begin
                     op_in    = node_rd;
                     node_we  = 1'b1;
                     node_wd  = {1'b0, inv_rd};
                     slot_ra  = node_rd[IDX_W-1:0];
                     state_in = ST_SLO;
                  end
               end
               default: begin
                  state_in = ST_QISS;
               end
            endcase
         end
         ST_RDB: begin
            same_in  = (pa_ff == node_rd);
            state_in = ST_QISS;
         end
         ST_SLO: begin
            rescan_in = 1'b0;
            slot_ra   = tp_ff;
            if (op_valid) begin
               oko_in  = slot_key(slot_rd);
               cnto_in = slot_rd.count - KEY_W'(1);
               slot_we = 1'b1;
               slot_wa = op_ff[IDX_W-1:0];
               if (slot_rd.count == KEY_W'(1)) begin
                  slot_wd = '{min_node: KEY_EMPTY, count: '0};
                  nko_in  = KEY_EMPTY;
               end else begin
                  slot_wd = '{min_node: slot_rd.min_node, count: slot_rd.count - KEY_W'(1)};
                  nko_in  = slot_rd.min_node;
                  rescan_in = (slot_rd.min_node == KEY_W'(a_ff));
               end
            end
            state_in = ST_SLT;
         end
         ST_SLT: begin
            okt_in  = slot_key(slot_rd);
            slot_we = 1'b1;
            slot_wa = tp_ff;
            if (slot_rd.count == '0 || KEY_W'(a_ff) < slot_rd.min_node) begin
               slot_wd = '{min_node: KEY_W'(a_ff), count: slot_rd.count + KEY_W'(1)};
               nkt_in  = KEY_W'(a_ff);
            end else begin
               slot_wd = '{min_node: slot_rd.min_node, count: slot_rd.count + KEY_W'(1)};
               nkt_in  = slot_rd.min_node;
            end
            u_in = '0; pend_in = 1'b0; rko_in = '0; rkt_in = '0;
            scan_in = '0; spend_in = 1'b0;
            state_in = rescan_ff ? ST_SCAN : ST_RANK;
         end
         ST_SCAN: begin
            node_ra  = scan_ff;
            scan_in  = scan_ff + NODE_W'(1);
            spend_in = 1'b1;
            sidx_in  = scan_ff;
            if (spend_ff && node_rd == op_ff) begin
               slot_we  = 1'b1;
               slot_wa  = op_ff[IDX_W-1:0];
               slot_wd  = '{min_node: KEY_W'(sidx_ff), count: cnto_ff};
               nko_in   = KEY_W'(sidx_ff);
               state_in = ST_RANK;
            end
         end
         ST_RANK: begin
            slot_ra = u_ff[IDX_W-1:0];
            rank_ra = u_ff[IDX_W-1:0];
            if (32'(u_ff) < COMMUNITIES) begin
               u_in    = u_ff + (IDX_W+1)'(1);
               pend_in = 1'b1;
               pv_in   = u_ff[IDX_W-1:0];
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (!v_is_o && !v_is_t) begin
                  rank_we = 1'b1;
                  inv_we  = 1'b1;
               end
               if (!v_is_t && ahead(kv, pv_ff, nkt_ff, tp_ff)) begin
                  rkt_in = rkt_ff + IDX_W'(1);
               end
               if (op_valid && !v_is_o && ahead(kv, pv_ff, nko_ff, op_ff[IDX_W-1:0])) begin
                  rko_in = rko_ff + IDX_W'(1);
               end
               if (32'(pv_ff) == COMMUNITIES - 1) begin
                  state_in = ST_FIXT;
               end
            end
         end
         ST_FIXT: begin
            rank_we = 1'b1; rank_wa = tp_ff; rank_wd = rkt_ff;
            inv_we  = 1'b1; inv_wa  = rkt_ff; inv_wd  = tp_ff;
            state_in = op_valid ? ST_FIXO : ST_QISS;
         end
         ST_FIXO: begin
            rank_we = 1'b1; rank_wa = op_ff[IDX_W-1:0]; rank_wd = rko_ff;
            inv_we  = 1'b1; inv_wa  = rko_ff; inv_wd  = op_ff[IDX_W-1:0];
            state_in = ST_QISS;
         end
         ST_QISS: begin
            rank_ra  = pa_ff[IDX_W-1:0];
            state_in = ST_QOUT;
         end
         ST_QOUT: begin
            rsp_in.community_of_a = (pa_ff == SLOT_NONE) ? -7'sd1 : 7'(rank_rd);
            rsp_in.same_community = (cmd_ff == CMD_TEST) ? same_ff : 1'b0;
            rsp_in.status         = 1'b0;
            rsp_valid_in          = 1'b1;
            state_in              = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         spend_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         spend_ff     <= spend_in;
      end
      cmd_ff <= cmd_in; a_ff <= a_in; b_ff <= b_in; t_ff <= t_in; tp_ff <= tp_in;
      pa_ff <= pa_in; op_ff <= op_in; same_ff <= same_in; rescan_ff <= rescan_in;
      oko_ff <= oko_in; okt_ff <= okt_in; nko_ff <= nko_in; nkt_ff <= nkt_in;
      cnto_ff <= cnto_in; u_ff <= u_in; pv_ff <= pv_in; rko_ff <= rko_in;
      rkt_ff <= rkt_in; scan_ff <= scan_in; sidx_ff <= sidx_in; rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
